// ----- hdl/swlc_pkg.sv -----
// Shared types and constants for the stop-and-wait link controller.
// Used by stop_and_wait_link_controller_top and its bench; depends on nothing else.
package swlc_pkg;

    localparam int QUEUE_DEPTH  = 16;
    localparam int SEQ_BITS     = 32;
    localparam int PAYLOAD_BITS = 32;
    localparam int TIMER_BITS   = 16;
    localparam int PTR_W        = $clog2(QUEUE_DEPTH);
    localparam int KIND_W       = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = TIMER_BITS;

    localparam logic [TIMER_BITS-1:0] TIMEOUT_RESET  = TIMER_BITS'(500);
    localparam logic [KIND_W-1:0]     MAX_KIND_RESET = KIND_W'(15);
    localparam logic [TIMER_BITS-1:0] TIMER_MAX      = {TIMER_BITS{1'b1}};
    localparam logic [PTR_W-1:0]      LAST_SLOT      = PTR_W'(QUEUE_DEPTH - 1);

    typedef enum logic [1:0] {
        REQ_ENQUEUE = 2'd0,
        REQ_TX_SLOT = 2'd1,
        REQ_RX      = 2'd2,
        REQ_TICK    = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_TRANSMIT = 3'd1,
        EV_DELIVER  = 3'd2,
        EV_DROP_FULL  = 3'd3,
        EV_DROP_STALE = 3'd4,
        EV_PEER_CLOSED = 3'd5
    } event_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACK     = 4'd0,
        KIND_NACK    = 4'd1,
        KIND_GOODBYE = 4'd2,
        KIND_DATA    = 4'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESEND_TIMEOUT = 2'd0,
        CFG_MAX_KNOWN_KIND = 2'd1
    } cfg_idx_t;

    localparam logic NACK_EXPECTED_ACK = 1'b0;
    localparam logic NACK_UNKNOWN_KIND = 1'b1;

    typedef struct packed {
        logic [2:0]              event_res;
        logic [KIND_W-1:0]       kind;
        logic                    wants_ack;
        logic [SEQ_BITS-1:0]     seq;
        logic [PAYLOAD_BITS-1:0] payload;
        logic                    is_resend;
        logic                    nack_reason;
    } result_t;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] idx);
        logic [PTR_W-1:0] nxt;
        if (idx == LAST_SLOT)
            nxt = '0;
        else
            nxt = idx + PTR_W'(1);
        return nxt;
    endfunction

endpackage

// ----- hdl/stop_and_wait_link_controller_top.sv -----
// Stop-and-wait link controller: transmit ring, ack/nack slot, resend timer.
// Depends on swlc_pkg.
//
// One event is accepted per clock (start high, busy low); busy is high only
// while reset is applied and for the first cycle after it. Every accepted event
// yields exactly one result, shown for one cycle with done high, after passing
// through the input register and then the decode and state update into the
// result register. The receiver cannot stall, so results must be taken as they
// come. Configuration writes are always ready and should be made only while no
// event is in flight.
module stop_and_wait_link_controller_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          req_type,
    input  logic [swlc_pkg::KIND_W-1:0]         frame_kind,
    input  logic                                wants_ack,
    input  logic [swlc_pkg::SEQ_BITS-1:0]       frame_seq,
    input  logic [swlc_pkg::PAYLOAD_BITS-1:0]   frame_payload,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [swlc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [swlc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                done,
    output logic [2:0]                          event_res,
    output logic [swlc_pkg::KIND_W-1:0]         out_kind,
    output logic                                out_wants_ack,
    output logic [swlc_pkg::SEQ_BITS-1:0]       out_seq,
    output logic [swlc_pkg::PAYLOAD_BITS-1:0]   out_payload,
    output logic                                is_resend,
    output logic                                nack_reason
);
    import swlc_pkg::*;

    // configuration
    logic [TIMER_BITS-1:0] resend_timeout_reg;
    logic [KIND_W-1:0]     max_known_kind_reg;

    // input register
    logic                    in_valid_reg;
    logic [1:0]              in_req_reg;
    logic [KIND_W-1:0]       in_kind_reg;
    logic                    in_wa_reg;
    logic [SEQ_BITS-1:0]     in_seq_reg;
    logic [PAYLOAD_BITS-1:0] in_pay_reg;

    // ring
    logic [KIND_W:0]         q_kind_flag [QUEUE_DEPTH];
    logic [PAYLOAD_BITS-1:0] q_payload   [QUEUE_DEPTH];
    logic                    q_wr_en;

    // link state
    logic                  busy_reg;
    logic [PTR_W-1:0]      head_reg, head_next;
    logic [PTR_W-1:0]      tail_reg, tail_next;
    logic                  waiting_reg, waiting_next;
    logic [SEQ_BITS-1:0]   head_seq_reg, head_seq_next;
    logic [TIMER_BITS-1:0] elapsed_reg, elapsed_next;
    logic [SEQ_BITS-1:0]   send_cnt_reg, send_cnt_next;
    logic [SEQ_BITS-1:0]   last_rx_reg, last_rx_next;
    logic                  ctrl_pend_reg, ctrl_pend_next;
    logic                  ctrl_nack_reg, ctrl_nack_next;
    logic                  ctrl_reason_reg, ctrl_reason_next;

    // result register
    logic    done_reg;
    result_t res_reg, res_next;

    // decode helpers
    logic [KIND_W:0]         head_kf;
    logic [PAYLOAD_BITS-1:0] head_pay;
    logic [PTR_W-1:0]        tail_adv;
    logic                    rx_ctl;
    logic                    rx_stale;
    logic [SEQ_BITS-1:0]     seq_inc;

    assign cfg_ready = 1'b1;
    assign busy      = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resend_timeout_reg <= TIMEOUT_RESET;
            max_known_kind_reg <= MAX_KIND_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RESEND_TIMEOUT: resend_timeout_reg <= cfg_data[TIMER_BITS-1:0];
                CFG_MAX_KNOWN_KIND: max_known_kind_reg <= cfg_data[KIND_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            in_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= 1'b0;
            in_valid_reg <= start && !busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            in_req_reg  <= req_type;
            in_kind_reg <= frame_kind;
            in_wa_reg   <= wants_ack;
            in_seq_reg  <= frame_seq;
            in_pay_reg  <= frame_payload;
        end
    end

    // ring storage, written at the tail
    always_ff @(posedge clk)
    begin
        if (q_wr_en)
        begin
            q_kind_flag[tail_reg] <= {in_wa_reg, in_kind_reg};
            q_payload[tail_reg]   <= in_pay_reg;
        end
    end

    assign head_kf  = q_kind_flag[head_reg];
    assign head_pay = q_payload[head_reg];
    assign tail_adv = ring_next(tail_reg);
    assign seq_inc  = send_cnt_reg + SEQ_BITS'(1);
    assign rx_ctl   = (in_kind_reg == KIND_ACK) || (in_kind_reg == KIND_NACK);
    assign rx_stale = !rx_ctl && (in_seq_reg <= last_rx_reg);

    always_comb
    begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        waiting_next     = waiting_reg;
        head_seq_next    = head_seq_reg;
        elapsed_next     = elapsed_reg;
        send_cnt_next    = send_cnt_reg;
        last_rx_next     = last_rx_reg;
        ctrl_pend_next   = ctrl_pend_reg;
        ctrl_nack_next   = ctrl_nack_reg;
        ctrl_reason_next = ctrl_reason_reg;
        q_wr_en          = 1'b0;
        res_next         = '0;

        if (in_valid_reg)
        begin
            case (in_req_reg)
                REQ_ENQUEUE:
                begin
                    if (tail_adv == head_reg)
                        res_next.event_res = EV_DROP_FULL;
                    else
                    begin
                        q_wr_en   = 1'b1;
                        tail_next = tail_adv;
                    end
                end
                REQ_TX_SLOT:
                begin
                    if (ctrl_pend_reg)
                    begin
                        ctrl_pend_next       = 1'b0;
                        res_next.event_res   = EV_TRANSMIT;
                        res_next.kind        = ctrl_nack_reg ? KIND_NACK : KIND_ACK;
                        res_next.nack_reason = ctrl_nack_reg && ctrl_reason_reg;
                    end
                    else if (waiting_reg)
                    begin
                        if (elapsed_reg > resend_timeout_reg)
                        begin
                            elapsed_next       = '0;
                            res_next.event_res = EV_TRANSMIT;
                            res_next.kind      = head_kf[KIND_W-1:0];
                            res_next.wants_ack = head_kf[KIND_W];
                            res_next.seq       = head_seq_reg;
                            res_next.payload   = head_pay;
                            res_next.is_resend = 1'b1;
                        end
                    end
                    else if (head_reg != tail_reg)
                    begin
                        send_cnt_next      = seq_inc;
                        res_next.event_res = EV_TRANSMIT;
                        res_next.kind      = head_kf[KIND_W-1:0];
                        res_next.wants_ack = head_kf[KIND_W];
                        res_next.seq       = seq_inc;
                        res_next.payload   = head_pay;
                        // hold the head until its ack arrives
                        if (head_kf[KIND_W])
                        begin
                            waiting_next  = 1'b1;
                            head_seq_next = seq_inc;
                            elapsed_next  = '0;
                        end
                        else
                            head_next = ring_next(head_reg);
                    end
                end
                REQ_RX:
                begin
                    if (waiting_reg && (in_kind_reg != KIND_ACK))
                    begin
                        // reject everything but an ack while a frame is outstanding
                        if (in_wa_reg)
                        begin
                            ctrl_pend_next   = 1'b1;
                            ctrl_reason_next = NACK_EXPECTED_ACK;
                            if (rx_stale)
                            begin
                                ctrl_nack_next     = 1'b0;
                                res_next.event_res = EV_DROP_STALE;
                            end
                            else
                                ctrl_nack_next = 1'b1;
                        end
                    end
                    else
                    begin
                        if (in_wa_reg)
                        begin
                            ctrl_pend_next   = 1'b1;
                            ctrl_nack_next   = 1'b0;
                            ctrl_reason_next = NACK_EXPECTED_ACK;
                        end
                        if (rx_stale)
                            res_next.event_res = EV_DROP_STALE;
                        else
                        begin
                            if (!rx_ctl)
                                last_rx_next = in_seq_reg;
                            if (in_kind_reg == KIND_ACK)
                            begin
                                if (waiting_reg)
                                begin
                                    waiting_next = 1'b0;
                                    head_next    = ring_next(head_reg);
                                end
                            end
                            else if (in_kind_reg == KIND_GOODBYE)
                                res_next.event_res = EV_PEER_CLOSED;
                            else if (in_kind_reg >= KIND_DATA)
                            begin
                                if (in_kind_reg <= max_known_kind_reg)
                                begin
                                    res_next.event_res = EV_DELIVER;
                                    res_next.kind      = in_kind_reg;
                                    res_next.seq       = in_seq_reg;
                                    res_next.payload   = in_pay_reg;
                                end
                                else if (in_wa_reg)
                                begin
                                    ctrl_nack_next   = 1'b1;
                                    ctrl_reason_next = NACK_UNKNOWN_KIND;
                                end
                            end
                        end
                    end
                end
                REQ_TICK:
                begin
                    if (elapsed_reg != TIMER_MAX)
                        elapsed_next = elapsed_reg + TIMER_BITS'(1);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg        <= '0;
            tail_reg        <= '0;
            waiting_reg     <= 1'b0;
            head_seq_reg    <= '0;
            elapsed_reg     <= '0;
            send_cnt_reg    <= '0;
            last_rx_reg     <= '0;
            ctrl_pend_reg   <= 1'b0;
            ctrl_nack_reg   <= 1'b0;
            ctrl_reason_reg <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            waiting_reg     <= waiting_next;
            head_seq_reg    <= head_seq_next;
            elapsed_reg     <= elapsed_next;
            send_cnt_reg    <= send_cnt_next;
            last_rx_reg     <= last_rx_next;
            ctrl_pend_reg   <= ctrl_pend_next;
            ctrl_nack_reg   <= ctrl_nack_next;
            ctrl_reason_reg <= ctrl_reason_next;
            done_reg        <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done          = done_reg;
    assign event_res     = res_reg.event_res;
    assign out_kind      = res_reg.kind;
    assign out_wants_ack = res_reg.wants_ack;
    assign out_seq       = res_reg.seq;
    assign out_payload   = res_reg.payload;
    assign is_resend     = res_reg.is_resend;
    assign nack_reason   = res_reg.nack_reason;

`ifndef SYNTHESIS
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted event produced no result");

    a_resend_is_tx: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_resend) |-> (event_res == EV_TRANSMIT) && out_wants_ack)
        else $error("resend flagged on a non-transmit result");

    a_deliver_data: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (event_res == EV_DELIVER)) |-> (out_kind >= KIND_DATA))
        else $error("delivered a control frame");

    a_wait_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        waiting_reg |-> (head_reg != tail_reg))
        else $error("waiting for ack with an empty ring");
`endif

endmodule

// ----- sim/stop_and_wait_link_controller_top_test.sv -----
// Self-checking bench for stop_and_wait_link_controller_top: directed and random events,
// with every result predicted by a scoreboard that tracks the link state itself.
// Depends on swlc_pkg and the controller RTL only.
module stop_and_wait_link_controller_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import swlc_pkg::*;

    localparam int          CLK_PERIOD     = 12;
    localparam int          RESET_CYCLES   = 3;
    localparam int          QUIET_LIMIT    = 3000;
    localparam int          DRAIN_CYCLES   = 4;
    localparam int          PHASE_ITEMS    = 190;
    localparam int unsigned REPORT_LIMIT   = 200;
    localparam int          TICK_BURST     = 6;
    localparam logic [SEQ_BITS-1:0]     SEQ_MAX = {SEQ_BITS{1'b1}};
    localparam logic [PAYLOAD_BITS-1:0] PAY_MAX = {PAYLOAD_BITS{1'b1}};

    class link_scoreboard;
        result_t               awaited_results[$];
        int unsigned           mismatch_count;

        bit [KIND_W:0]         slot_kind_ack [QUEUE_DEPTH];
        bit [PAYLOAD_BITS-1:0] slot_payload [QUEUE_DEPTH];
        bit [PTR_W-1:0]        head_slot;
        bit [PTR_W-1:0]        tail_slot;
        bit                    awaiting_ack;
        bit [SEQ_BITS-1:0]     unacked_seq;
        bit [TIMER_BITS-1:0]   ticks_since_send;
        bit [SEQ_BITS-1:0]     last_sent_seq;
        bit [SEQ_BITS-1:0]     newest_rx_seq;
        bit                    reply_pending;
        bit                    reply_is_nack;
        bit                    reply_reason;
        bit [TIMER_BITS-1:0]   resend_after;
        bit [KIND_W-1:0]       top_data_kind;

        function new();
            resend_after  = TIMEOUT_RESET;
            top_data_kind = MAX_KIND_RESET;
        endfunction

        function bit [PTR_W-1:0] next_slot(bit [PTR_W-1:0] idx);
            return (idx == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
        endfunction

        function void set_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_RESEND_TIMEOUT: resend_after  = data[TIMER_BITS-1:0];
                CFG_MAX_KNOWN_KIND: top_data_kind = data[KIND_W-1:0];
                default: ;
            endcase
        endfunction

        // a newer ack or nack overwrites one still waiting for a slot
        function void queue_reply(bit nack, bit reason);
            reply_pending = 1'b1;
            reply_is_nack = nack;
            reply_reason  = reason;
        endfunction

        function result_t link_response(req_t req, logic [KIND_W-1:0] kind, logic wa,
                                        logic [SEQ_BITS-1:0] seq,
                                        logic [PAYLOAD_BITS-1:0] pay);
            result_t         res;
            bit [PTR_W-1:0]  nxt;
            bit [KIND_W:0]   head_entry;
            bit              control;
            bit              stale;
            res = '0;
            res.event_res = EV_NONE;
            head_entry = slot_kind_ack[head_slot];
            case (req)
                REQ_ENQUEUE:
                begin
                    nxt = next_slot(tail_slot);
                    if (nxt == head_slot)
                        res.event_res = EV_DROP_FULL;
                    else
                    begin
                        slot_kind_ack[tail_slot] = {wa, kind};
                        slot_payload[tail_slot]  = pay;
                        tail_slot = nxt;
                    end
                end
                REQ_TX_SLOT:
                begin
                    if (reply_pending)
                    begin
                        reply_pending   = 1'b0;
                        res.event_res   = EV_TRANSMIT;
                        res.kind        = reply_is_nack ? KIND_NACK : KIND_ACK;
                        res.nack_reason = reply_is_nack & reply_reason;
                    end
                    else if (awaiting_ack)
                    begin
                        if (ticks_since_send > resend_after)
                        begin
                            ticks_since_send = '0;
                            res.event_res = EV_TRANSMIT;
                            res.kind      = head_entry[KIND_W-1:0];
                            res.wants_ack = head_entry[KIND_W];
                            res.seq       = unacked_seq;
                            res.payload   = slot_payload[head_slot];
                            res.is_resend = 1'b1;
                        end
                    end
                    else if (head_slot != tail_slot)
                    begin
                        last_sent_seq = last_sent_seq + 1'b1;
                        res.event_res = EV_TRANSMIT;
                        res.kind      = head_entry[KIND_W-1:0];
                        res.wants_ack = head_entry[KIND_W];
                        res.seq       = last_sent_seq;
                        res.payload   = slot_payload[head_slot];
                        // hold the head until its ack arrives
                        if (head_entry[KIND_W])
                        begin
                            awaiting_ack     = 1'b1;
                            unacked_seq      = last_sent_seq;
                            ticks_since_send = '0;
                        end
                        else
                            head_slot = next_slot(head_slot);
                    end
                end
                REQ_RX:
                begin
                    control = (kind == KIND_ACK) || (kind == KIND_NACK);
                    stale   = !control && (seq <= newest_rx_seq);
                    if (awaiting_ack && kind != KIND_ACK)
                    begin
                        // rejected while waiting: last_rx stays put
                        if (wa)
                        begin
                            if (stale)
                            begin
                                queue_reply(1'b0, NACK_EXPECTED_ACK);
                                res.event_res = EV_DROP_STALE;
                            end
                            else
                                queue_reply(1'b1, NACK_EXPECTED_ACK);
                        end
                    end
                    else
                    begin
                        if (wa)
                            queue_reply(1'b0, NACK_EXPECTED_ACK);
                        if (stale)
                            res.event_res = EV_DROP_STALE;
                        else
                        begin
                            if (!control)
                                newest_rx_seq = seq;
                            if (kind == KIND_ACK)
                            begin
                                if (awaiting_ack)
                                begin
                                    awaiting_ack = 1'b0;
                                    head_slot    = next_slot(head_slot);
                                end
                            end
                            else if (kind == KIND_GOODBYE)
                                res.event_res = EV_PEER_CLOSED;
                            else if (kind >= KIND_DATA)
                            begin
                                if (kind <= top_data_kind)
                                begin
                                    res.event_res = EV_DELIVER;
                                    res.kind      = kind;
                                    res.seq       = seq;
                                    res.payload   = pay;
                                end
                                else if (wa)
                                    queue_reply(1'b1, NACK_UNKNOWN_KIND);
                            end
                        end
                    end
                end
                default:
                begin
                    if (ticks_since_send != TIMER_MAX)
                        ticks_since_send = ticks_since_send + 1'b1;
                end
            endcase
            return res;
        endfunction

        function void note_event(req_t req, logic [KIND_W-1:0] kind, logic wa,
                                 logic [SEQ_BITS-1:0] seq, logic [PAYLOAD_BITS-1:0] pay);
            awaited_results.push_back(link_response(req, kind, wa, seq, pay));
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (awaited_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $error("event_res: expected no result, got 0x%0h", got.event_res);
                return;
            end
            want = awaited_results.pop_front();
            compare_field("event_res", want.event_res, got.event_res);
            compare_field("out_kind", want.kind, got.kind);
            compare_field("out_wants_ack", want.wants_ack, got.wants_ack);
            compare_field("out_seq", want.seq, got.seq);
            compare_field("out_payload", want.payload, got.payload);
            compare_field("is_resend", want.is_resend, got.is_resend);
            compare_field("nack_reason", want.nack_reason, got.nack_reason);
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [1:0]              req_type;
    logic [KIND_W-1:0]       frame_kind;
    logic                    wants_ack;
    logic [SEQ_BITS-1:0]     frame_seq;
    logic [PAYLOAD_BITS-1:0] frame_payload;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    done;
    logic [2:0]              event_res;
    logic [KIND_W-1:0]       out_kind;
    logic                    out_wants_ack;
    logic [SEQ_BITS-1:0]     out_seq;
    logic [PAYLOAD_BITS-1:0] out_payload;
    logic                    is_resend;
    logic                    nack_reason;

    int unsigned             quiet_cycles = 0;
    link_scoreboard          sb = new();

    stop_and_wait_link_controller_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .frame_kind    (frame_kind),
        .wants_ack     (wants_ack),
        .frame_seq     (frame_seq),
        .frame_payload (frame_payload),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .done          (done),
        .event_res     (event_res),
        .out_kind      (out_kind),
        .out_wants_ack (out_wants_ack),
        .out_seq       (out_seq),
        .out_payload   (out_payload),
        .is_resend     (is_resend),
        .nack_reason   (nack_reason)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        result_t seen;
        if (rst_n && done)
        begin
            seen.event_res   = event_res;
            seen.kind        = out_kind;
            seen.wants_ack   = out_wants_ack;
            seen.seq         = out_seq;
            seen.payload     = out_payload;
            seen.is_resend   = is_resend;
            seen.nack_reason = nack_reason;
            sb.check_result(seen);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Leaves start high; the caller either sends the next word or drops start.
    task automatic send_event(input req_t req, input logic [KIND_W-1:0] kind, input logic wa,
                              input logic [SEQ_BITS-1:0] seq,
                              input logic [PAYLOAD_BITS-1:0] pay);
        start         <= 1'b1;
        req_type      <= req;
        frame_kind    <= kind;
        wants_ack     <= wa;
        frame_seq     <= seq;
        frame_payload <= pay;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_event(req, kind, wa, seq, pay);
    endtask

    task automatic wait_for_drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic apply_settings(input logic [TIMER_BITS-1:0] timeout,
                                  input logic [KIND_W-1:0] top_kind);
        logic [CFG_DATA_W-1:0] kind_word;
        // junk in the unused upper bits must be masked off
        kind_word = {(CFG_DATA_W - KIND_W)'($urandom()), top_kind};
        wait_for_drain();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_RESEND_TIMEOUT;
        cfg_data  <= CFG_DATA_W'(timeout);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_register(CFG_RESEND_TIMEOUT, CFG_DATA_W'(timeout));
        cfg_index <= CFG_MAX_KNOWN_KIND;
        cfg_data  <= kind_word;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_register(CFG_MAX_KNOWN_KIND, kind_word);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_event(input int unsigned idle_pct);
        int unsigned         pick;
        int unsigned         flavor;
        req_t                req;
        logic [KIND_W-1:0]   kind;
        logic                wa;
        logic [SEQ_BITS-1:0] seq;
        logic [PAYLOAD_BITS-1:0] pay;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        pick = $urandom_range(0, 99);
        kind = KIND_W'($urandom_range(0, 15));
        wa   = 1'($urandom_range(0, 1));
        seq  = $urandom();
        pay  = $urandom();
        if (pick < 24)
            req = REQ_ENQUEUE;
        else if (pick < 52)
            req = REQ_TX_SLOT;
        else if (pick < 78)
        begin
            req = REQ_RX;
            flavor = $urandom_range(0, 9);
            if (sb.awaiting_ack && $urandom_range(0, 1))
                kind = KIND_ACK;
            else if (flavor < 6)
            begin
                // fresh frame just past the newest seen
                kind = KIND_W'($urandom_range(KIND_GOODBYE, 15));
                seq  = sb.newest_rx_seq + SEQ_BITS'($urandom_range(1, 1000));
            end
            else if (flavor < 8)
            begin
                kind = KIND_W'($urandom_range(KIND_GOODBYE, 15));
                seq  = $urandom_range(0, sb.newest_rx_seq);
            end
            else
                kind = $urandom_range(0, 1) ? KIND_NACK : KIND_ACK;
        end
        else
            req = REQ_TICK;
        send_event(req, kind, wa, seq, pay);
    endtask

    task automatic run_phase(input logic [TIMER_BITS-1:0] timeout,
                             input logic [KIND_W-1:0] top_kind, input int unsigned idle_pct);
        apply_settings(timeout, top_kind);
        for (int n = 0; n < PHASE_ITEMS; n++)
            random_event(idle_pct);
    endtask

    task automatic directed_events();
        apply_settings(TIMER_BITS'(2), MAX_KIND_RESET);
        send_event(REQ_TX_SLOT, KIND_ACK, 1'b0, '0, '0);          // nothing queued
        send_event(REQ_RX, KIND_ACK, 1'b0, SEQ_MAX, '0);          // stray ack while idle
        send_event(REQ_ENQUEUE, KIND_DATA, 1'b1, '0, PAY_MAX);
        send_event(REQ_ENQUEUE, KIND_W'(15), 1'b0, SEQ_MAX, '0);
        send_event(REQ_TX_SLOT, KIND_ACK, 1'b0, '0, '0);          // seq 1, now waiting
        send_event(REQ_RX, KIND_W'(5), 1'b1, SEQ_BITS'(10), PAYLOAD_BITS'(32'h1234_5678));
        send_event(REQ_RX, KIND_W'(5), 1'b1, '0, '0);             // stale while waiting
        send_event(REQ_RX, KIND_W'(4), 1'b0, SEQ_BITS'(11), '0);  // ignored while waiting
        send_event(REQ_TX_SLOT, KIND_ACK, 1'b0, '0, '0);
        send_event(REQ_TX_SLOT, KIND_ACK, 1'b0, '0, '0);          // timer not expired
        repeat (3)
            send_event(REQ_TICK, KIND_ACK, 1'b0, '0, '0);
        send_event(REQ_TX_SLOT, KIND_ACK, 1'b0, '0, '0);          // resend
        send_event(REQ_RX, KIND_ACK, 1'b0, '0, '0);
        send_event(REQ_TX_SLOT, KIND_ACK, 1'b0, '0, '0);
        send_event(REQ_RX, KIND_W'(15), 1'b1, SEQ_BITS'(5), PAY_MAX);
        send_event(REQ_RX, KIND_DATA, 1'b1, SEQ_BITS'(5), '0);    // stale, still acked
        send_event(REQ_RX, KIND_GOODBYE, 1'b0, SEQ_BITS'(6), '0);
        send_event(REQ_RX, KIND_NACK, 1'b1, '0, '0);
        send_event(REQ_TX_SLOT, KIND_ACK, 1'b0, '0, '0);
        apply_settings(TIMER_BITS'(2), KIND_DATA);
        send_event(REQ_RX, KIND_W'(4), 1'b1, SEQ_BITS'(7), '0);   // unknown kind
        send_event(REQ_TX_SLOT, KIND_ACK, 1'b0, '0, '0);

        // top timeout: the head is never resent, nor just below it after a few ticks
        apply_settings(TIMER_MAX, KIND_DATA);
        send_event(REQ_ENQUEUE, KIND_DATA, 1'b1, '0, PAYLOAD_BITS'(32'hA5A5_5A5A));
        send_event(REQ_TX_SLOT, KIND_ACK, 1'b0, '0, '0);
        repeat (TICK_BURST)
            send_event(REQ_TICK, KIND_ACK, 1'b0, '0, '0);
        send_event(REQ_TX_SLOT, KIND_ACK, 1'b0, '0, '0);
        apply_settings(TIMER_MAX - 1'b1, KIND_DATA);
        send_event(REQ_TX_SLOT, KIND_ACK, 1'b0, '0, '0);
        send_event(REQ_RX, KIND_ACK, 1'b0, '0, '0);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        req_type      = REQ_ENQUEUE;
        frame_kind    = KIND_ACK;
        wants_ack     = 1'b0;
        frame_seq     = '0;
        frame_payload = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_RESEND_TIMEOUT;
        cfg_data      = '0;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;

        directed_events();

        run_phase(TIMER_BITS'(1), MAX_KIND_RESET, 0);
        run_phase(TIMER_BITS'(4), KIND_DATA, 88);
        run_phase(TIMEOUT_RESET, KIND_W'(9), 0);
        run_phase(TIMER_BITS'(2), KIND_W'(4), 33);
        run_phase(TIMER_MAX, MAX_KIND_RESET, 88);
        run_phase(TIMER_BITS'(3), KIND_DATA, 0);
        run_phase(TIMER_BITS'(8), KIND_W'(12), 33);
        run_phase(TIMER_BITS'(1), KIND_W'(7), 88);

        // top sequence number last, since nothing is fresh after it
        send_event(REQ_RX, KIND_ACK, 1'b0, '0, '0);
        send_event(REQ_RX, KIND_DATA, 1'b1, SEQ_MAX, PAY_MAX);
        send_event(REQ_RX, KIND_DATA, 1'b1, SEQ_MAX, '0);

        wait_for_drain();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (sb.mismatch_count == 0 && sb.awaited_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
